// ===== hdl/ptfc_pkg.sv =====
// ---------------------------------------------------------------------------
// ptfc_pkg
// Shared types, constants and the byte-wise CRC-32 step for the telemetry
// framer.
// ---------------------------------------------------------------------------
package ptfc_pkg;

  localparam int unsigned FrameLen     = 28;
  localparam int unsigned CrcLen       = 24;
  localparam int unsigned IdxW         = $clog2(FrameLen);

  localparam logic [31:0] PeriodReset  = 32'd500;
  localparam logic [31:0] BootReset    = 32'd0;
  localparam logic [31:0] CrcPoly      = 32'hEDB88320;
  localparam logic [31:0] CrcInit      = 32'hFFFFFFFF;
  localparam logic [31:0] MsgType      = 32'h00000002;
  localparam logic [7:0]  SyncHi       = 8'h4B;
  localparam logic [7:0]  SyncLo       = 8'h34;
  localparam logic [7:0]  FrameVer     = 8'h01;
  localparam logic [7:0]  FillByte     = 8'hFF;

  // Operation codes
  localparam logic OpTick    = 1'b0;
  localparam logic OpOutcome = 1'b1;

  // Register indexes (byte address 4*i)
  localparam int unsigned AddrW     = 3;
  localparam logic        RegPeriod = 1'b0;
  localparam logic        RegBoot   = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] now_ms;
    logic        sent_ok;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       led_on;
  } out_item_t;

  // Control from the sequencer to the CRC unit
  typedef struct packed {
    logic       init;
    logic       update;
    logic [7:0] data;
  } crc_ctl_t;

  // Fold one byte into a reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/ptfc_crc.sv =====
// ---------------------------------------------------------------------------
// ptfc_crc
// Running CRC-32 register: one byte folded in per cycle on request.
// ---------------------------------------------------------------------------
module ptfc_crc (
  input  logic               clk,
  input  logic               rst,
  input  ptfc_pkg::crc_ctl_t ctl,
  output logic [31:0]        crc
);
  import ptfc_pkg::*;

  // Reload at frame start, otherwise fold in the offered byte
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CrcInit;
    end else if (ctl.init) begin
      crc <= CrcInit;
    end else if (ctl.update) begin
      crc <= crc_byte(crc, ctl.data);
    end
  end

endmodule

// ===== hdl/ptfc_seq.sv =====
// ---------------------------------------------------------------------------
// ptfc_seq
// Frame sequencer: decides on ticks, keeps send time, sequence number and
// LED level, and walks the 28 frame bytes through the output register.
// ---------------------------------------------------------------------------
module ptfc_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         period_ms,
  input  logic [31:0]         boot_marker,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptfc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ptfc_pkg::out_item_t out_item,
  output ptfc_pkg::crc_ctl_t  crc_ctl,
  input  logic [31:0]         crc
);
  import ptfc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t          state;
  logic [IdxW-1:0] idx;
  logic [31:0]     last_send_ms;
  logic [31:0]     sequence_number;
  logic            led_level;
  logic [31:0]     elapsed;
  logic [31:0]     crc_out;
  logic [7:0]      cur_byte;
  logic            slot_free;
  logic            byte_load;
  logic            in_fire;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign elapsed   = in_item.now_ms - last_send_ms;
  assign slot_free = !out_valid || out_ready;
  assign byte_load = (state == ST_EMIT) && slot_free;
  assign crc_out   = ~crc;

  // Select the frame byte at the current position
  always_comb begin
    case (idx)
      5'd0:    cur_byte = SyncHi;
      5'd1:    cur_byte = SyncLo;
      5'd2:    cur_byte = FrameVer;
      5'd3:    cur_byte = 8'(FrameLen);
      5'd4:    cur_byte = sequence_number[7:0];
      5'd5:    cur_byte = sequence_number[15:8];
      5'd6:    cur_byte = sequence_number[23:16];
      5'd7:    cur_byte = sequence_number[31:24];
      5'd8:    cur_byte = last_send_ms[7:0];
      5'd9:    cur_byte = last_send_ms[15:8];
      5'd10:   cur_byte = last_send_ms[23:16];
      5'd11:   cur_byte = last_send_ms[31:24];
      5'd12:   cur_byte = MsgType[7:0];
      5'd13:   cur_byte = MsgType[15:8];
      5'd14:   cur_byte = MsgType[23:16];
      5'd15:   cur_byte = MsgType[31:24];
      5'd16:   cur_byte = boot_marker[7:0];
      5'd17:   cur_byte = boot_marker[15:8];
      5'd18:   cur_byte = boot_marker[23:16];
      5'd19:   cur_byte = boot_marker[31:24];
      5'd20:   cur_byte = FillByte;
      5'd21:   cur_byte = FillByte;
      5'd24:   cur_byte = crc_out[7:0];
      5'd25:   cur_byte = crc_out[15:8];
      5'd26:   cur_byte = crc_out[23:16];
      5'd27:   cur_byte = crc_out[31:24];
      default: cur_byte = 8'h00;
    endcase
  end

  // Drive the CRC unit: reload on a new frame, fold the header bytes
  always_comb begin
    crc_ctl.init   = in_fire && (in_item.op == OpTick) && (elapsed >= period_ms);
    crc_ctl.update = byte_load && (idx < IdxW'(CrcLen));
    crc_ctl.data   = cur_byte;
  end

  // Hold state, counters and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      idx             <= '0;
      last_send_ms    <= '0;
      sequence_number <= '0;
      led_level       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      // Load a byte into a free slot, else drop the one just taken
      if (byte_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_item.op == OpOutcome) begin
              if (in_item.sent_ok) begin
                sequence_number <= sequence_number + 32'd1;
              end
            end else if (elapsed >= period_ms) begin
              last_send_ms <= in_item.now_ms;
              led_level    <= ~led_level;
              idx          <= '0;
              state        <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_item.frame_byte <= cur_byte;
            out_item.last_byte  <= (idx == IdxW'(FrameLen - 1));
            out_item.led_on     <= led_level;
            idx                 <= idx + 1'b1;
            if (idx == IdxW'(FrameLen - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/periodic_telemetry_framer_crc32_unit.sv =====
// ---------------------------------------------------------------------------
// periodic_telemetry_framer_crc32_unit
// Periodic telemetry framer emitting 28-byte frames closed by a CRC-32.
// ---------------------------------------------------------------------------
// A transmit outcome report, or a tick that finds the period not yet elapsed,
// is taken while the block idles and gives no bytes. A tick that starts a
// frame holds in_ready low while its 28 bytes are loaded into the output
// register, one byte per cycle unless out_ready stalls; the byte-serial CRC
// register, which folds in one header byte per cycle, sets that pace. The CRC
// covers bytes 0 to 23 and is sent little-endian in bytes 24 to 27. Registers:
// period_ms at 0x0 (reset 500), boot_marker at 0x4 (reset 0); write them only while the block idles.
module periodic_telemetry_framer_crc32_unit #(
  parameter logic [31:0] PERIOD_RESET = ptfc_pkg::PeriodReset,
  parameter logic [31:0] BOOT_RESET   = ptfc_pkg::BootReset
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptfc_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ptfc_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ptfc_pkg::out_item_t           out_item
);
  import ptfc_pkg::*;

  logic [31:0] period_ms;
  logic [31:0] boot_marker;
  logic        reg_sel;
  crc_ctl_t    crc_ctl;
  logic [31:0] crc;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms   <= PERIOD_RESET;
      boot_marker <= BOOT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        RegPeriod: period_ms   <= pwdata;
        RegBoot:   boot_marker <= pwdata;
        default:   period_ms   <= period_ms;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_sel)
      RegPeriod: prdata = period_ms;
      RegBoot:   prdata = boot_marker;
      default:   prdata = '0;
    endcase
  end

  ptfc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .period_ms   (period_ms),
    .boot_marker (boot_marker),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .crc_ctl     (crc_ctl),
    .crc         (crc)
  );

  ptfc_crc u_crc (
    .clk (clk),
    .rst (rst),
    .ctl (crc_ctl),
    .crc (crc)
  );

endmodule

// ===== hdl/ptfc_checker.sv =====
// ---------------------------------------------------------------------------
// ptfc_checker
// Port-level checks for the telemetry framer, bound to the top level.
// ---------------------------------------------------------------------------
module ptfc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input ptfc_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input ptfc_pkg::out_item_t out_item
);
  import ptfc_pkg::*;

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  // Keep input closed while a frame is only partly out
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last_byte |-> !in_ready)
    else $error("input open in the middle of a frame");

  // Reports never start a frame
  a_report: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_item.op == OpOutcome) |=> in_ready)
    else $error("outcome report blocked the input");

  // A new frame opens with the sync byte
  a_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_item.last_byte |=>
      !out_valid || (out_item.frame_byte == SyncHi))
    else $error("frame does not start with the sync byte");

endmodule

bind periodic_telemetry_framer_crc32_unit ptfc_checker u_ptfc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
